### rtl/core/complex_arithmetic_unit_defines.svh
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define CAU_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define CAU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/core/cau_pkg.sv
// Operation and status codes of the complex arithmetic unit.
package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } st_e;

endpackage

### rtl/core/complex_arithmetic_unit.sv
// Pipelined complex add/sub/mul/div with saturation and modulus.
//
//  channel  dir  signals                      contents (lowest bit up)
//  s_axis   in   tvalid tready tdata tuser    tdata: a_real a_imag b_real b_imag; tuser: operation
//  m_axis   out  tvalid tready tdata          tdata: result_real result_imag magnitude status
//
// One item per cycle sustained while m_axis_tready is held high; the pipeline length is set by the
// bit-per-stage divider (DATA_WIDTH+2 stages) and square root (DATA_WIDTH stages).
// Reset clears only the stage valid bits.
// A stage holds while the one after it is full and stalled; empty stages
// still fill, so input is taken while a result waits.
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // a_real, a_imag, b_real, b_imag
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  // operation
  input  logic [1:0]                             s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // result_real, result_imag, magnitude, status
  output logic [((3*DATA_WIDTH+2+7)/8)*8-1:0]    m_axis_tdata
);
  import cau_pkg::*;

  localparam int W      = DATA_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int RW     = 2*W+1;
  localparam int AW     = 2*W+1+F;
  localparam int OUT_W  = ((3*W+2+7)/8)*8;
  localparam int K_MUL  = 1;
  localparam int K_CMB  = 2;
  localparam int K_DIV0 = 3;
  localparam int K_DIVB = 4;
  localparam int K_CLP  = 5+W;
  localparam int K_SQR  = 6+W;
  localparam int K_SUM  = 7+W;
  localparam int K_RT0  = 8+W;
  localparam int NST    = 8+2*W;

  localparam logic signed [RW-1:0] MAXV  = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [RW-1:0] MINV  = ~MAXV;
  localparam logic signed [RW-1:0] FMASK = RW'((64'd1 << F) - 64'd1);

  typedef struct packed {
    op_e                   op;
    logic signed [W-1:0]   ar;
    logic signed [W-1:0]   ai;
    logic signed [W-1:0]   br;
    logic signed [W-1:0]   bi;
    logic signed [2*W-1:0] prr;
    logic signed [2*W-1:0] pii;
    logic signed [2*W-1:0] pri;
    logic signed [2*W-1:0] pir;
    logic signed [2*W-1:0] pdr;
    logic signed [2*W-1:0] pdi;
    logic signed [RW-1:0]  re_raw;
    logic signed [RW-1:0]  im_raw;
    logic                  nre;
    logic                  nim;
    logic [AW-1:0]         are;
    logic [AW-1:0]         aim;
    logic [2*W-1:0]        den;
    logic                  dz;
    logic [2*W:0]          rre;
    logic [2*W:0]          rim;
    logic [W:0]            qre;
    logic [W:0]            qim;
    logic                  ore;
    logic                  oim;
    logic signed [W-1:0]   res_re;
    logic signed [W-1:0]   res_im;
    st_e                   st;
    logic [2*W-1:0]        sqre;
    logic [2*W-1:0]        sqim;
    logic [2*W-1:0]        x;
    logic [W+1:0]          rem;
    logic [W-1:0]          root;
  } pipe_t;

  pipe_t        p_q [NST];
  pipe_t        p_d [NST];
  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  assign rdy[NST] = m_axis_tready;
  assign s_axis_tready = rdy[0];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    assign rdy[k] = ~v_q[k] | rdy[k+1];

    if (k == 0) begin : g_in
      always_comb begin
        p_d[k]    = '0;
        p_d[k].op = op_e'(s_axis_tuser);
        p_d[k].ar = s_axis_tdata[W-1:0];
        p_d[k].ai = s_axis_tdata[2*W-1:W];
        p_d[k].br = s_axis_tdata[3*W-1:2*W];
        p_d[k].bi = s_axis_tdata[4*W-1:3*W];
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_q[k] <= s_axis_tvalid;
        end
      end
      always_ff @(posedge clk_i) begin
        if (rdy[k] && s_axis_tvalid) begin
          p_q[k] <= p_d[k];
        end
      end
    end else begin : g_mid
      if (k == K_MUL) begin : g_mul
        always_comb begin
          p_d[k]     = p_q[k-1];
          p_d[k].prr = p_q[k-1].ar * p_q[k-1].br;
          p_d[k].pii = p_q[k-1].ai * p_q[k-1].bi;
          p_d[k].pri = p_q[k-1].ar * p_q[k-1].bi;
          p_d[k].pir = p_q[k-1].ai * p_q[k-1].br;
          p_d[k].pdr = p_q[k-1].br * p_q[k-1].br;
          p_d[k].pdi = p_q[k-1].bi * p_q[k-1].bi;
        end
      end else if (k == K_CMB) begin : g_cmb
        always_comb begin
          logic signed [RW-1:0] dr;
          logic signed [RW-1:0] di;
          logic [RW-1:0]        ur;
          logic [RW-1:0]        ui;
          p_d[k]        = p_q[k-1];
          p_d[k].re_raw = '0;
          p_d[k].im_raw = '0;
          dr = RW'(p_q[k-1].prr) - RW'(p_q[k-1].pii);
          di = RW'(p_q[k-1].pri) + RW'(p_q[k-1].pir);
          unique case (p_q[k-1].op)
            OP_ADD: begin
              p_d[k].re_raw = RW'(p_q[k-1].ar) + RW'(p_q[k-1].br);
              p_d[k].im_raw = RW'(p_q[k-1].ai) + RW'(p_q[k-1].bi);
            end
            OP_SUB: begin
              p_d[k].re_raw = RW'(p_q[k-1].ar) - RW'(p_q[k-1].br);
              p_d[k].im_raw = RW'(p_q[k-1].ai) - RW'(p_q[k-1].bi);
            end
            OP_MUL: begin
              p_d[k].re_raw = $signed(dr + (dr[RW-1] ? FMASK : '0)) >>> F;
              p_d[k].im_raw = $signed(di + (di[RW-1] ? FMASK : '0)) >>> F;
            end
            OP_DIV: begin
              dr = RW'(p_q[k-1].prr) + RW'(p_q[k-1].pii);
              di = RW'(p_q[k-1].pir) - RW'(p_q[k-1].pri);
            end
            default: ;
          endcase
          ur = dr[RW-1] ? RW'(-dr) : RW'(dr);
          ui = di[RW-1] ? RW'(-di) : RW'(di);
          p_d[k].nre = dr[RW-1];
          p_d[k].nim = di[RW-1];
          p_d[k].are = AW'(ur) << F;
          p_d[k].aim = AW'(ui) << F;
          p_d[k].den = (2*W)'($unsigned(p_q[k-1].pdr)) + (2*W)'($unsigned(p_q[k-1].pdi));
          p_d[k].dz  = (p_d[k].den == '0);
        end
      end else if (k == K_DIV0) begin : g_div0
        always_comb begin
          logic [AW-1:0] hr;
          logic [AW-1:0] hi;
          p_d[k]     = p_q[k-1];
          hr         = p_q[k-1].are >> (W+1);
          hi         = p_q[k-1].aim >> (W+1);
          p_d[k].ore = (hr >= AW'(p_q[k-1].den));
          p_d[k].oim = (hi >= AW'(p_q[k-1].den));
          p_d[k].rre = (2*W+1)'(hr);
          p_d[k].rim = (2*W+1)'(hi);
          p_d[k].qre = '0;
          p_d[k].qim = '0;
        end
      end else if (k < K_CLP) begin : g_divb
        localparam int B = W - (k - K_DIVB);
        always_comb begin
          logic [2*W:0] tr;
          logic [2*W:0] ti;
          logic [2*W:0] dd;
          p_d[k] = p_q[k-1];
          dd = {1'b0, p_q[k-1].den};
          tr = {p_q[k-1].rre[2*W-1:0], p_q[k-1].are[B]};
          ti = {p_q[k-1].rim[2*W-1:0], p_q[k-1].aim[B]};
          if (tr >= dd) begin
            p_d[k].rre = tr - dd;
            p_d[k].qre = {p_q[k-1].qre[W-1:0], 1'b1};
          end else begin
            p_d[k].rre = tr;
            p_d[k].qre = {p_q[k-1].qre[W-1:0], 1'b0};
          end
          if (ti >= dd) begin
            p_d[k].rim = ti - dd;
            p_d[k].qim = {p_q[k-1].qim[W-1:0], 1'b1};
          end else begin
            p_d[k].rim = ti;
            p_d[k].qim = {p_q[k-1].qim[W-1:0], 1'b0};
          end
        end
      end else if (k == K_CLP) begin : g_clp
        always_comb begin
          logic [RW-1:0]        mr;
          logic [RW-1:0]        mi;
          logic signed [RW-1:0] vr;
          logic signed [RW-1:0] vi;
          logic                 sat;
          p_d[k] = p_q[k-1];
          mr = p_q[k-1].ore ? (RW'(1) << W) : RW'(p_q[k-1].qre);
          mi = p_q[k-1].oim ? (RW'(1) << W) : RW'(p_q[k-1].qim);
          vr = p_q[k-1].re_raw;
          vi = p_q[k-1].im_raw;
          if (p_q[k-1].op == OP_DIV) begin
            vr = p_q[k-1].nre ? -$signed(mr) : $signed(mr);
            vi = p_q[k-1].nim ? -$signed(mi) : $signed(mi);
          end
          sat = 1'b0;
          if (vr > MAXV) begin
            vr  = MAXV;
            sat = 1'b1;
          end else if (vr < MINV) begin
            vr  = MINV;
            sat = 1'b1;
          end
          if (vi > MAXV) begin
            vi  = MAXV;
            sat = 1'b1;
          end else if (vi < MINV) begin
            vi  = MINV;
            sat = 1'b1;
          end
          p_d[k].res_re = W'(vr);
          p_d[k].res_im = W'(vi);
          p_d[k].st     = sat ? ST_SAT : ST_OK;
          if (p_q[k-1].op == OP_DIV && p_q[k-1].dz) begin
            p_d[k].res_re = '0;
            p_d[k].res_im = '0;
            p_d[k].st     = ST_DZ;
          end
        end
      end else if (k == K_SQR) begin : g_sqr
        always_comb begin
          logic [W-1:0] ur;
          logic [W-1:0] ui;
          p_d[k] = p_q[k-1];
          ur = p_q[k-1].res_re[W-1] ? W'(-p_q[k-1].res_re) : W'(p_q[k-1].res_re);
          ui = p_q[k-1].res_im[W-1] ? W'(-p_q[k-1].res_im) : W'(p_q[k-1].res_im);
          p_d[k].sqre = ur * ur;
          p_d[k].sqim = ui * ui;
        end
      end else if (k == K_SUM) begin : g_sum
        always_comb begin
          p_d[k]      = p_q[k-1];
          p_d[k].x    = p_q[k-1].sqre + p_q[k-1].sqim;
          p_d[k].rem  = '0;
          p_d[k].root = '0;
        end
      end else begin : g_rt
        localparam int I = W - 1 - (k - K_RT0);
        always_comb begin
          logic [W+1:0] rn;
          logic [W+1:0] tv;
          p_d[k] = p_q[k-1];
          rn = {p_q[k-1].rem[W-1:0], p_q[k-1].x[2*I+1:2*I]};
          tv = {p_q[k-1].root, 2'b01};
          if (rn >= tv) begin
            p_d[k].rem  = rn - tv;
            p_d[k].root = {p_q[k-1].root[W-2:0], 1'b1};
          end else begin
            p_d[k].rem  = rn;
            p_d[k].root = {p_q[k-1].root[W-2:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (rdy[k] && v_q[k-1]) begin
          p_q[k] <= p_d[k];
        end
      end
    end
  end

  assign m_axis_tvalid = v_q[NST-1];
  assign m_axis_tdata  = OUT_W'({p_q[NST-1].st, p_q[NST-1].root,
                                 p_q[NST-1].res_im, p_q[NST-1].res_re});

  `CAU_ASSERT(a_dz_zero, m_axis_tvalid && p_q[NST-1].st == ST_DZ, p_q[NST-1].res_re == '0 && p_q[NST-1].res_im == '0 && p_q[NST-1].root == '0, "divide by zero result not zero")
  `CAU_ASSERT(a_sat_limit, m_axis_tvalid && p_q[NST-1].st == ST_SAT, p_q[NST-1].res_re == W'(MAXV) || p_q[NST-1].res_re == W'(MINV) || p_q[NST-1].res_im == W'(MAXV) || p_q[NST-1].res_im == W'(MINV), "saturated status without a part at a limit")
  `CAU_ASSERT(a_rdy_empty, !m_axis_tvalid, s_axis_tready, "input stalled with output stage empty")
  `CAU_ASSERT_NEXT(a_take, s_axis_tvalid && s_axis_tready, v_q[0], "accepted item not captured")

endmodule
